// ===== sv/btcp_pkg.sv =====
package btcp_pkg;

	localparam int TEAM_W   = 10;
	localparam int WORKER_W = 8;
	localparam int NUMA_W   = 6;
	localparam int CORE_W   = 9;
	localparam int CFG_IW   = 3;
	localparam int CFG_DW   = 11;

	localparam logic [CFG_IW-1:0] REG_TEAMS       = 3'd0;
	localparam logic [CFG_IW-1:0] REG_WORKERS     = 3'd1;
	localparam logic [CFG_IW-1:0] REG_NUMA_IN_USE = 3'd2;
	localparam logic [CFG_IW-1:0] REG_CORES_IN_USE = 3'd3;
	localparam logic [CFG_IW-1:0] REG_NUMA_OFFSET = 3'd4;
	localparam logic [CFG_IW-1:0] REG_CORE_OFFSET = 3'd5;
	localparam logic [CFG_IW-1:0] REG_MASTER_NUMA = 3'd6;
	localparam logic [CFG_IW-1:0] REG_MASTER_CORE = 3'd7;

	typedef struct packed {
		logic       ok;
		logic       tsel;
		logic [7:0] worker;
	} tside_t;

	typedef struct packed {
		logic       ok;
		logic       cinb;
		logic [8:0] k;
		logic [7:0] nsum;
	} cside_t;

endpackage

// ===== sv/balanced_thread_core_placement.sv =====
// balanced thread-to-core placement
//
// request channel: team_index and worker_index, taken when req_valid is high
// and req_stall is low. result channel: numa_index, core_index and rank_valid,
// taken when res_valid is high and res_stall is low. an out-of-range rank
// gives rank_valid 0 with zero coordinates.
// configuration: cfg_valid/cfg_ready write port, cfg_index selects the
// register, cfg_data carries the value; cfg_ready is always high.
// one request per cycle while req_stall is low. the result path is built from
// three bit-per-stage divider pipelines (team split, worker split over cores,
// final wrap-around). after reset and after every configuration write a
// sequential unit derives the partition bins and the rotation; req_stall is
// held high during that time. reset clears all valid bits and loads register
// defaults. when the receiver stalls a held result, the whole pipeline
// freezes and req_stall rises in the same cycle; nothing is dropped or
// repeated.
module balanced_thread_core_placement (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [btcp_pkg::TEAM_W-1:0]   team_index,
	input  logic [btcp_pkg::WORKER_W-1:0] worker_index,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [btcp_pkg::NUMA_W-1:0]   numa_index,
	output logic [btcp_pkg::CORE_W-1:0]   core_index,
	output logic                          rank_valid,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [btcp_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [btcp_pkg::CFG_DW-1:0]   cfg_data
);
	import btcp_pkg::*;

	typedef enum logic [3:0] {
		ST_START, ST_DIV_N, ST_MUL_N, ST_MUL_WA, ST_DIV_A,
		ST_MUL_A, ST_DIV_B, ST_MUL_B, ST_OFF, ST_IDLE
	} state_t;

	localparam int TD = 10;
	localparam int CD = 20;
	localparam int MD = 10;

	// configuration registers
	logic [10:0] tc_q;
	logic [8:0]  wpt_q;
	logic [6:0]  nu_q;
	logic [8:0]  cu_q;
	logic [5:0]  noff_q;
	logic [7:0]  coff_q;
	logic [5:0]  mnuma_q;
	logic [7:0]  mcore_q;

	logic [6:0] nu_eff;
	logic [8:0] cu_eff;
	logic       cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign nu_eff    = (nu_q == 7'd0) ? 7'd1 : nu_q;
	assign cu_eff    = (cu_q == 9'd0) ? 9'd1 : cu_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q    <= 11'd1;
			wpt_q   <= 9'd1;
			nu_q    <= 7'd1;
			cu_q    <= 9'd1;
			noff_q  <= '0;
			coff_q  <= '0;
			mnuma_q <= '0;
			mcore_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_TEAMS:        tc_q    <= cfg_data;
				REG_WORKERS:      wpt_q   <= cfg_data[8:0];
				REG_NUMA_IN_USE:  nu_q    <= cfg_data[6:0];
				REG_CORES_IN_USE: cu_q    <= cfg_data[8:0];
				REG_NUMA_OFFSET:  noff_q  <= cfg_data[5:0];
				REG_CORE_OFFSET:  coff_q  <= cfg_data[7:0];
				REG_MASTER_NUMA:  mnuma_q <= cfg_data[5:0];
				REG_MASTER_CORE:  mcore_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// derived partition constants
	state_t      state_q;
	logic [19:0] dv_dvd_q;
	logic [8:0]  dv_dvs_q;
	logic [8:0]  dv_rem_q;
	logic [4:0]  dv_cnt_q;
	logic [10:0] nbin_q;
	logic [6:0]  nk_q;
	logic [10:0] npart_q;
	logic [19:0] wca_q;
	logic [19:0] cbina_q;
	logic [8:0]  ka_q;
	logic [19:0] parta_q;
	logic [19:0] cbinb_q;
	logic [8:0]  kb_q;
	logic [19:0] partb_q;
	logic [5:0]  offn_q;
	logic [7:0]  offc_q;

	logic [9:0]  dv_r;
	logic        dv_ge;
	logic [8:0]  dv_rem_n;
	logic [19:0] dv_dvd_n;
	logic [6:0]  nk_w;
	logic [8:0]  kc_w;
	logic [19:0] wca_w;
	logic [6:0]  ln0;
	logic [8:0]  lc0;
	logic [7:0]  n0;
	logic [9:0]  c0;
	logic        busy;

	always_comb begin
		dv_r     = {dv_rem_q, dv_dvd_q[19]};
		dv_ge    = dv_r >= {1'b0, dv_dvs_q};
		dv_rem_n = dv_ge ? 9'(dv_r - {1'b0, dv_dvs_q}) : dv_r[8:0];
		dv_dvd_n = {dv_dvd_q[18:0], dv_ge};
		nk_w     = nu_eff - dv_rem_q[6:0];
		kc_w     = cu_eff - dv_rem_q;
		wca_w    = 20'(nbin_q) * 20'(wpt_q);
		if (npart_q != 11'd0) begin
			ln0 = '0;
			lc0 = (parta_q != 20'd0) ? 9'd0 : ka_q;
		end else begin
			ln0 = nk_q;
			lc0 = (partb_q != 20'd0) ? 9'd0 : kb_q;
		end
		n0 = 8'(noff_q) + 8'(ln0);
		c0 = 10'(coff_q) + 10'(lc0);
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_START;
			dv_dvd_q <= '0;
			dv_dvs_q <= '0;
			dv_rem_q <= '0;
			dv_cnt_q <= '0;
			nbin_q   <= '0;
			nk_q     <= '0;
			npart_q  <= '0;
			wca_q    <= '0;
			cbina_q  <= '0;
			ka_q     <= '0;
			parta_q  <= '0;
			cbinb_q  <= '0;
			kb_q     <= '0;
			partb_q  <= '0;
			offn_q   <= '0;
			offc_q   <= '0;
		end else if (cfg_wr) begin
			state_q <= ST_START;
		end else begin
			unique case (state_q)
				ST_START: begin
					dv_dvd_q <= 20'(tc_q);
					dv_dvs_q <= 9'(nu_eff);
					dv_rem_q <= '0;
					dv_cnt_q <= '0;
					state_q  <= ST_DIV_N;
				end
				ST_DIV_N, ST_DIV_A, ST_DIV_B: begin
					dv_dvd_q <= dv_dvd_n;
					dv_rem_q <= dv_rem_n;
					dv_cnt_q <= dv_cnt_q + 5'd1;
					if (dv_cnt_q == 5'd19) begin
						unique case (state_q)
							ST_DIV_N: state_q <= ST_MUL_N;
							ST_DIV_A: state_q <= ST_MUL_A;
							default:  state_q <= ST_MUL_B;
						endcase
					end
				end
				ST_MUL_N: begin
					nbin_q  <= dv_dvd_q[10:0];
					nk_q    <= nk_w;
					npart_q <= 11'(18'(nk_w) * 18'(dv_dvd_q[10:0]));
					state_q <= ST_MUL_WA;
				end
				ST_MUL_WA: begin
					wca_q    <= wca_w;
					dv_dvd_q <= wca_w;
					dv_dvs_q <= cu_eff;
					dv_rem_q <= '0;
					dv_cnt_q <= '0;
					state_q  <= ST_DIV_A;
				end
				ST_MUL_A: begin
					cbina_q  <= dv_dvd_q;
					ka_q     <= kc_w;
					parta_q  <= 20'(29'(kc_w) * 29'(dv_dvd_q));
					dv_dvd_q <= wca_q + 20'(wpt_q);
					dv_rem_q <= '0;
					dv_cnt_q <= '0;
					state_q  <= ST_DIV_B;
				end
				ST_MUL_B: begin
					cbinb_q <= dv_dvd_q;
					kb_q    <= kc_w;
					partb_q <= 20'(29'(kc_w) * 29'(dv_dvd_q));
					state_q <= ST_OFF;
				end
				ST_OFF: begin
					offn_q  <= (8'(mnuma_q) > n0) ? 6'(8'(mnuma_q) - n0) : 6'd0;
					offc_q  <= (10'(mcore_q) > c0) ? 8'(10'(mcore_q) - c0) : 8'd0;
					state_q <= ST_IDLE;
				end
				ST_IDLE: ;
				default: state_q <= ST_START;
			endcase
		end
	end

	// pipeline control
	logic en;
	logic req_acc;

	assign en        = !res_valid || !res_stall;
	assign req_stall = busy || !en;
	assign req_acc   = req_valid && !req_stall;

	// team split: divide by bin or bin+1
	logic        tdv_vld_s [0:TD];
	logic [9:0]  tdv_dvd_s [0:TD];
	logic [11:0] tdv_dvs_s [0:TD];
	logic [11:0] tdv_rem_s [0:TD];
	tside_t      tdv_sb_s  [0:TD];

	logic        t_inb;
	logic [10:0] t_diff;
	logic        t_ok;

	always_comb begin
		t_inb  = {1'b0, team_index} < npart_q;
		t_diff = {1'b0, team_index} - npart_q;
		t_ok   = ({1'b0, team_index} < tc_q) && ({1'b0, worker_index} < wpt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tdv_vld_s[0] <= 1'b0;
		end else if (en) begin
			tdv_vld_s[0] <= req_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tdv_dvd_s[0] <= t_inb ? team_index : t_diff[9:0];
			tdv_dvs_s[0] <= t_inb ? {1'b0, nbin_q} : ({1'b0, nbin_q} + 12'd1);
			tdv_rem_s[0] <= '0;
			tdv_sb_s[0]  <= '{ok: t_ok, tsel: !t_inb, worker: worker_index};
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < TD; gi++) begin : g_tdiv
			logic [12:0] r;
			logic        ge;
			always_comb begin
				r  = {tdv_rem_s[gi], tdv_dvd_s[gi][TD-1]};
				ge = r >= {1'b0, tdv_dvs_s[gi]};
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					tdv_vld_s[gi+1] <= 1'b0;
				end else if (en) begin
					tdv_vld_s[gi+1] <= tdv_vld_s[gi];
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					tdv_rem_s[gi+1] <= ge ? 12'(r - {1'b0, tdv_dvs_s[gi]}) : r[11:0];
					tdv_dvd_s[gi+1] <= {tdv_dvd_s[gi][TD-2:0], ge};
					tdv_dvs_s[gi+1] <= tdv_dvs_s[gi];
					tdv_sb_s[gi+1]  <= tdv_sb_s[gi];
				end
			end
		end
	endgenerate

	// worker rank and region sum
	logic        vld_s12;
	logic        ok_s12;
	logic        tsel_s12;
	logic [19:0] wrank_s12;
	logic [7:0]  nsum_s12;
	logic [10:0] ln_w;

	assign ln_w = tdv_sb_s[TD].tsel ? (11'(nk_q) + 11'(tdv_dvd_s[TD]))
	                                : 11'(tdv_dvd_s[TD]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s12 <= 1'b0;
		end else if (en) begin
			vld_s12 <= tdv_vld_s[TD];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s12    <= tdv_sb_s[TD].ok;
			tsel_s12  <= tdv_sb_s[TD].tsel;
			wrank_s12 <= 20'(tdv_rem_s[TD][9:0]) * 20'(wpt_q) + 20'(tdv_sb_s[TD].worker);
			nsum_s12  <= 8'(noff_q) + 8'(ln_w[6:0]) + 8'(offn_q);
		end
	end

	// worker split over cores
	logic        cdv_vld_s [0:CD];
	logic [19:0] cdv_dvd_s [0:CD];
	logic [20:0] cdv_dvs_s [0:CD];
	logic [20:0] cdv_rem_s [0:CD];
	cside_t      cdv_sb_s  [0:CD];

	logic [19:0] c_part;
	logic [19:0] c_bin;
	logic        c_inb;

	always_comb begin
		c_part = tsel_s12 ? partb_q : parta_q;
		c_bin  = tsel_s12 ? cbinb_q : cbina_q;
		c_inb  = wrank_s12 < c_part;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cdv_vld_s[0] <= 1'b0;
		end else if (en) begin
			cdv_vld_s[0] <= vld_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cdv_dvd_s[0] <= c_inb ? wrank_s12 : (wrank_s12 - c_part);
			cdv_dvs_s[0] <= c_inb ? {1'b0, c_bin} : ({1'b0, c_bin} + 21'd1);
			cdv_rem_s[0] <= '0;
			cdv_sb_s[0]  <= '{ok: ok_s12, cinb: c_inb, k: (tsel_s12 ? kb_q : ka_q),
			                  nsum: nsum_s12};
		end
	end

	generate
		for (gi = 0; gi < CD; gi++) begin : g_cdiv
			logic [21:0] r;
			logic        ge;
			always_comb begin
				r  = {cdv_rem_s[gi], cdv_dvd_s[gi][CD-1]};
				ge = r >= {1'b0, cdv_dvs_s[gi]};
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					cdv_vld_s[gi+1] <= 1'b0;
				end else if (en) begin
					cdv_vld_s[gi+1] <= cdv_vld_s[gi];
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					cdv_rem_s[gi+1] <= ge ? 21'(r - {1'b0, cdv_dvs_s[gi]}) : r[20:0];
					cdv_dvd_s[gi+1] <= {cdv_dvd_s[gi][CD-2:0], ge};
					cdv_dvs_s[gi+1] <= cdv_dvs_s[gi];
					cdv_sb_s[gi+1]  <= cdv_sb_s[gi];
				end
			end
		end
	endgenerate

	// rotation wrap: region mod regions in use, core mod cores in use
	logic       mdv_vld_s  [0:MD];
	logic       mdv_ok_s   [0:MD];
	logic [9:0] mdv_ndvd_s [0:MD];
	logic [6:0] mdv_nrem_s [0:MD];
	logic [9:0] mdv_cdvd_s [0:MD];
	logic [8:0] mdv_crem_s [0:MD];

	logic [19:0] lc_w;
	assign lc_w = cdv_sb_s[CD].cinb ? cdv_dvd_s[CD]
	                                : (cdv_dvd_s[CD] + 20'(cdv_sb_s[CD].k));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mdv_vld_s[0] <= 1'b0;
		end else if (en) begin
			mdv_vld_s[0] <= cdv_vld_s[CD];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mdv_ok_s[0]   <= cdv_sb_s[CD].ok;
			mdv_ndvd_s[0] <= 10'(cdv_sb_s[CD].nsum);
			mdv_nrem_s[0] <= '0;
			mdv_cdvd_s[0] <= 10'(lc_w[8:0]) + 10'(offc_q);
			mdv_crem_s[0] <= '0;
		end
	end

	generate
		for (gi = 0; gi < MD; gi++) begin : g_mdiv
			logic [7:0] rn;
			logic [9:0] rc;
			logic       gen;
			logic       gec;
			always_comb begin
				rn  = {mdv_nrem_s[gi], mdv_ndvd_s[gi][MD-1]};
				rc  = {mdv_crem_s[gi], mdv_cdvd_s[gi][MD-1]};
				gen = rn >= {1'b0, nu_eff};
				gec = rc >= {1'b0, cu_eff};
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					mdv_vld_s[gi+1] <= 1'b0;
				end else if (en) begin
					mdv_vld_s[gi+1] <= mdv_vld_s[gi];
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					mdv_ok_s[gi+1]   <= mdv_ok_s[gi];
					mdv_nrem_s[gi+1] <= gen ? 7'(rn - {1'b0, nu_eff}) : rn[6:0];
					mdv_ndvd_s[gi+1] <= {mdv_ndvd_s[gi][MD-2:0], 1'b0};
					mdv_crem_s[gi+1] <= gec ? 9'(rc - {1'b0, cu_eff}) : rc[8:0];
					mdv_cdvd_s[gi+1] <= {mdv_cdvd_s[gi][MD-2:0], 1'b0};
				end
			end
		end
	endgenerate

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (en) begin
			res_valid <= mdv_vld_s[MD];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rank_valid <= mdv_ok_s[MD];
			numa_index <= mdv_ok_s[MD] ? mdv_nrem_s[MD][5:0] : '0;
			core_index <= mdv_ok_s[MD] ? (9'(coff_q) + mdv_crem_s[MD]) : '0;
		end
	end

`ifndef SYNTHESIS
	a_cfg_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> req_stall)
		else $error("request taken while constants are recomputed");

	a_zero_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !rank_valid |-> numa_index == '0 && core_index == '0)
		else $error("out-of-range rank with nonzero coordinates");

	a_numa_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && rank_valid |-> {1'b0, numa_index} < nu_eff)
		else $error("region index not below regions in use");
`endif

endmodule

// ===== tb/tb_balanced_thread_core_placement.sv =====
`timescale 1ns / 100ps

module tb_balanced_thread_core_placement;
	import btcp_pkg::*;

	typedef struct {
		logic [NUMA_W-1:0] numa;
		logic [CORE_W-1:0] core;
		logic              ok;
	} placement_t;

	class placement_board;
		int unsigned teams = 1;
		int unsigned workers = 1;
		int unsigned numa_use = 1;
		int unsigned cores_use = 1;
		int unsigned numa_off = 0;
		int unsigned core_off = 0;
		int unsigned master_numa = 0;
		int unsigned master_core = 0;
		placement_t pending[$];
		int errors = 0;

		function void write_reg(logic [CFG_IW-1:0] idx, int unsigned v);
			case (idx)
			REG_TEAMS: teams = v & 'h7ff;
			REG_WORKERS: workers = v & 'h1ff;
			REG_NUMA_IN_USE: numa_use = v & 'h7f;
			REG_CORES_IN_USE: cores_use = v & 'h1ff;
			REG_NUMA_OFFSET: numa_off = v & 'h3f;
			REG_CORE_OFFSET: core_off = v & 'hff;
			REG_MASTER_NUMA: master_numa = v & 'h3f;
			REG_MASTER_CORE: master_core = v & 'hff;
			default: ;
			endcase
		endfunction

		function void place_unrotated(int unsigned team, int unsigned worker,
				int unsigned nu, int unsigned cu, output int unsigned n, output int unsigned c);
			int unsigned bin, bin1, k, part, trank, tcount, wcount, wrank;
			bin = teams / nu;
			bin1 = bin + 1;
			k = nu * bin1 - teams;
			part = k * bin;
			if (team < part) begin
				n = numa_off + team / bin;
				trank = team % bin;
				tcount = bin;
			end else begin
				n = numa_off + k + (team - part) / bin1;
				trank = (team - part) % bin1;
				tcount = bin1;
			end
			wcount = tcount * workers;
			wrank = trank * workers + worker;
			bin = wcount / cu;
			bin1 = bin + 1;
			k = cu * bin1 - wcount;
			part = k * bin;
			if (wrank < part)
				c = core_off + wrank / bin;
			else
				c = core_off + k + (wrank - part) / bin1;
		endfunction

		function void note_request(int unsigned team, int unsigned worker);
			int unsigned nu, cu, n0, c0, n, c, rn, rc;
			placement_t p;
			nu = numa_use ? numa_use : 1;
			cu = cores_use ? cores_use : 1;
			if (team >= teams || worker >= workers) begin
				p.numa = '0;
				p.core = '0;
				p.ok = 1'b0;
			end else begin
				place_unrotated(0, 0, nu, cu, n0, c0);
				rn = (n0 < master_numa) ? master_numa - n0 : 0;
				rc = (c0 < master_core) ? master_core - c0 : 0;
				place_unrotated(team, worker, nu, cu, n, c);
				n = (n + rn) % nu;
				c = core_off + (c + rc - core_off) % cu;
				p.numa = n[NUMA_W-1:0];
				p.core = c[CORE_W-1:0];
				p.ok = 1'b1;
			end
			pending.push_back(p);
		endfunction

		function void check_result(logic [NUMA_W-1:0] n, logic [CORE_W-1:0] c, logic ok);
			placement_t p;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result numa %0d core %0d valid %0b", n, c, ok);
				return;
			end
			p = pending.pop_front();
			if (p.numa !== n || p.core !== c || p.ok !== ok) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected numa %0d core %0d valid %0b, got %0d %0d %0b",
						p.numa, p.core, p.ok, n, c, ok);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	logic [TEAM_W-1:0] team_index;
	logic [WORKER_W-1:0] worker_index;
	logic res_valid;
	logic res_stall;
	logic [NUMA_W-1:0] numa_index;
	logic [CORE_W-1:0] core_index;
	logic rank_valid;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;

	placement_board board;
	bit stall_enable;

	balanced_thread_core_placement u_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.team_index(team_index), .worker_index(worker_index),
		.res_valid(res_valid), .res_stall(res_stall),
		.numa_index(numa_index), .core_index(core_index), .rank_valid(rank_valid),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("FAILURE");
		$finish;
	end

	function automatic int unsigned gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(5, 40);
		if ($urandom_range(0, 2) == 0)
			return $urandom_range(1, 3);
		return 0;
	endfunction

	// receiver: random stalls, result checked when taken
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			board.check_result(numa_index, core_index, rank_valid);
		if (stall_enable && $urandom_range(0, 3) == 0)
			res_stall <= 1'b1;
		else if (stall_enable && $urandom_range(0, 60) == 0)
			res_stall <= 1'b1;
		else
			res_stall <= 1'b0;
	end

	task automatic send_request(int unsigned team, int unsigned worker);
		int unsigned g;
		g = gap_len();
		if (g != 0) begin
			req_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req_valid <= 1'b1;
		team_index <= team[TEAM_W-1:0];
		worker_index <= worker[WORKER_W-1:0];
		@(posedge clk);
		while (req_stall) @(posedge clk);
		board.note_request(team, worker);
	endtask

	task automatic drain();
		int unsigned guard;
		guard = 0;
		req_valid <= 1'b0;
		while (board.pending.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IW-1:0] idx, int unsigned v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v[CFG_DW-1:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.write_reg(idx, v);
	endtask

	task automatic configure(int unsigned tc, int unsigned wk, int unsigned nu, int unsigned cu,
			int unsigned no, int unsigned co, int unsigned mn, int unsigned mc);
		drain();
		write_reg(REG_TEAMS, tc);
		write_reg(REG_WORKERS, wk);
		write_reg(REG_NUMA_IN_USE, nu);
		write_reg(REG_CORES_IN_USE, cu);
		write_reg(REG_NUMA_OFFSET, no);
		write_reg(REG_CORE_OFFSET, co);
		write_reg(REG_MASTER_NUMA, mn);
		write_reg(REG_MASTER_CORE, mc);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(int unsigned count);
		int unsigned t, w;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 7) == 0) begin
				t = $urandom_range(0, 1023);
				w = $urandom_range(0, 255);
			end else begin
				t = $urandom_range(0, board.teams ? board.teams - 1 : 0);
				w = $urandom_range(0, board.workers ? board.workers - 1 : 0);
			end
			send_request(t, w);
		end
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		team_index = '0;
		worker_index = '0;
		res_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		stall_enable = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults, both in and out of range
		send_request(0, 0);
		send_request(1, 0);
		send_request(0, 1);
		send_request(1023, 255);

		configure(1024, 256, 64, 256, 63, 255, 63, 255);
		send_request(0, 0);
		send_request(1023, 255);
		send_request(512, 128);
		send_request(1023, 0);
		configure(0, 5, 3, 4, 1, 2, 0, 0);
		send_request(0, 0);
		configure(10, 0, 3, 4, 1, 2, 0, 0);
		send_request(0, 0);
		configure(7, 3, 0, 0, 2, 3, 0, 0);
		send_request(6, 2);
		send_request(3, 1);
		configure(10, 3, 4, 5, 2, 3, 0, 0);
		send_request(0, 0);
		send_request(9, 2);
		configure(10, 3, 4, 5, 0, 0, 3, 4);
		send_request(0, 0);
		send_request(9, 2);
		send_request(10, 0);
		send_request(0, 3);
		configure(2047, 511, 127, 511, 0, 0, 5, 9);
		send_request(1023, 255);
		send_request(700, 100);

		stall_enable = 1;
		for (int ph = 0; ph < 14; ph++) begin
			configure($urandom_range(1, 1024), $urandom_range(1, 256), $urandom_range(1, 64),
				$urandom_range(1, 256), $urandom_range(0, 63), $urandom_range(0, 255),
				$urandom_range(0, 63), $urandom_range(0, 255));
			random_phase(60);
			drain();
			random_phase(60);
		end
		configure(1, 1, 1, 1, 0, 0, 0, 0);
		random_phase(20);
		configure(3, 2, 64, 256, 0, 255, 63, 0);
		random_phase(30);
		drain();
		stall_enable = 0;
		@(posedge clk);
		drain();

		if (board.errors == 0 && board.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

// ===== filelist.f =====
sv/btcp_pkg.sv
sv/balanced_thread_core_placement.sv
tb/tb_balanced_thread_core_placement.sv
